@@ design/rtfc_pkg.sv @@
// shared types, codes and constants for the region table fault check block
package rtfc_pkg;

  localparam int unsigned DefMaxRegions = 16;

  // request function codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_FAULT  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_REGION = 3'd1;
  localparam logic [2:0] ST_DENIED    = 3'd2;
  localparam logic [2:0] ST_BAD_RANGE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // permission and fault code bit positions
  localparam int unsigned PERM_READ_BIT  = 0;
  localparam int unsigned PERM_WRITE_BIT = 1;
  localparam int unsigned PERM_EXEC_BIT  = 2;
  localparam int unsigned FC_PRESENT_BIT = 0;
  localparam int unsigned FC_WRITE_BIT   = 1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] region_start;
    logic [31:0] region_end;
    logic [2:0]  region_perm;
    logic [31:0] fault_addr;
    logic [1:0]  fault_code;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] hit_start;
    logic [31:0] hit_end;
    logic [2:0]  hit_perm;
    logic        page_writable;
  } rsp_t;

  typedef struct packed {
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    logic [2:0]  perm;
  } entry_t;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_LAST,
    RD_SHIFT
  } rd_sel_e;

  typedef enum logic {
    RES_PLAIN,
    RES_HIT
  } res_sel_e;

  // controller to datapath
  typedef struct packed {
    logic       load_req;
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       scan_clr;
    logic       scan_step;
    logic       take_prev;
    logic       take_next;
    logic       pos_at_j;
    logic       shift_init;
    logic       shift_write;
    logic       ins_write;
    logic       hit_last;
    logic       hit_scan;
    logic       clear_tab;
    logic       res_load;
    res_sel_e   res_sel;
    logic [2:0] res_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       range_bad;
    logic       j_at_count;
    logic       lh_usable;
    logic       rd_holds;
    logic       rd_le;
    logic       overlap;
    logic       full;
    logic       shift_done;
    logic       out_busy;
  } sts_t;

endpackage

@@ design/rtfc_ctrl.sv @@
// sequencing state machine for insert, fault check and clear requests
module rtfc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  rtfc_pkg::sts_t sts_i,
  output rtfc_pkg::cmd_t cmd_o
);
  import rtfc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_EV,
    S_INS_CHK,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_FC_LAST,
    S_FC_RD,
    S_FC_EV
  } state_e;

  state_e state_q, state_d;

  assign req_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel     = RD_SCAN;
    cmd_o.res_sel    = RES_PLAIN;
    cmd_o.res_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.func)
          FUNC_INSERT: begin
            if (sts_i.range_bad) begin
              if (!sts_i.out_busy) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_BAD_RANGE;
                state_d = S_IDLE;
              end
            end else begin
              cmd_o.scan_clr = 1'b1;
              state_d = S_INS_RD;
            end
          end
          FUNC_FAULT: begin
            if (sts_i.lh_usable) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_LAST;
              state_d = S_FC_LAST;
            end else begin
              cmd_o.scan_clr = 1'b1;
              state_d = S_FC_RD;
            end
          end
          FUNC_CLEAR: begin
            if (!sts_i.out_busy) begin
              cmd_o.clear_tab = 1'b1;
              cmd_o.res_load  = 1'b1;
              state_d = S_IDLE;
            end
          end
          default: begin
            if (!sts_i.out_busy) begin
              cmd_o.res_load = 1'b1;
              state_d = S_IDLE;
            end
          end
        endcase
      end
      S_INS_RD: begin
        if (sts_i.j_at_count) begin
          cmd_o.pos_at_j = 1'b1;
          state_d = S_INS_CHK;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = S_INS_EV;
        end
      end
      S_INS_EV: begin
        if (sts_i.rd_le) begin
          cmd_o.take_prev = 1'b1;
          cmd_o.scan_step = 1'b1;
          state_d = S_INS_RD;
        end else begin
          cmd_o.pos_at_j  = 1'b1;
          cmd_o.take_next = 1'b1;
          state_d = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (sts_i.overlap || sts_i.full) begin
          if (!sts_i.out_busy) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = sts_i.overlap ? ST_BAD_RANGE : ST_FULL;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.shift_init = 1'b1;
          state_d = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (sts_i.shift_done) begin
          state_d = S_INS_WR;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_SHIFT;
          state_d = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.shift_write = 1'b1;
        state_d = S_SH_RD;
      end
      S_INS_WR: begin
        if (!sts_i.out_busy) begin
          cmd_o.ins_write = 1'b1;
          cmd_o.res_load  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FC_LAST: begin
        if (sts_i.rd_holds) begin
          if (!sts_i.out_busy) begin
            cmd_o.hit_last = 1'b1;
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_HIT;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.scan_clr = 1'b1;
          state_d = S_FC_RD;
        end
      end
      S_FC_RD: begin
        if (sts_i.j_at_count) begin
          if (!sts_i.out_busy) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_NO_REGION;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = S_FC_EV;
        end
      end
      S_FC_EV: begin
        if (sts_i.rd_holds) begin
          if (!sts_i.out_busy) begin
            cmd_o.hit_scan = 1'b1;
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_HIT;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d = S_FC_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/rtfc_datapath.sv @@
// region table memory, scan registers, compares and result register
module rtfc_datapath #(
  parameter int unsigned MaxRegions = rtfc_pkg::DefMaxRegions
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rtfc_pkg::cmd_t cmd_i,
  output rtfc_pkg::sts_t sts_o,
  input  rtfc_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_stall_i,
  output rtfc_pkg::rsp_t rsp_o
);
  import rtfc_pkg::*;

  localparam int unsigned IW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
  localparam int unsigned CW = $clog2(MaxRegions + 1);

  entry_t table_mem [MaxRegions];

  req_t          req_q;
  entry_t        rd_q;
  logic [31:0]   prev_end_q, next_start_q;
  logic          has_prev_q, has_next_q;
  logic [CW-1:0] j_q, pos_q, count_q;
  logic [IW-1:0] lh_idx_q;
  logic          lh_valid_q;
  logic          out_valid_q;
  rsp_t          rsp_q, rsp_d;

  logic [CW-1:0] j_m1;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;
  logic          allowed;

  assign j_m1 = j_q - CW'(1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_SCAN:  rd_addr = j_q[IW-1:0];
      RD_LAST:  rd_addr = lh_idx_q;
      RD_SHIFT: rd_addr = j_m1[IW-1:0];
      default:  rd_addr = j_q[IW-1:0];
    endcase
  end

  // a shift moves the entry read last into slot j, the final write lands the new region
  assign wr_addr = cmd_i.shift_write ? j_q[IW-1:0] : pos_q[IW-1:0];
  always_comb begin
    if (cmd_i.shift_write) begin
      wr_data = rd_q;
    end else begin
      wr_data.start_addr = req_q.region_start;
      wr_data.end_addr   = req_q.region_end;
      wr_data.perm       = req_q.region_perm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_write || cmd_i.ins_write) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= table_mem[rd_addr];
    end
  end

  // status towards the controller
  assign sts_o.func       = req_q.func;
  assign sts_o.range_bad  = req_q.region_start >= req_q.region_end;
  assign sts_o.j_at_count = (j_q == count_q);
  assign sts_o.lh_usable  = lh_valid_q && (CW'(lh_idx_q) < count_q);
  assign sts_o.rd_holds   = (rd_q.start_addr <= req_q.fault_addr) &&
                            (req_q.fault_addr < rd_q.end_addr);
  assign sts_o.rd_le      = rd_q.start_addr <= req_q.region_start;
  assign sts_o.overlap    = (has_prev_q && (prev_end_q > req_q.region_start)) ||
                            (has_next_q && (req_q.region_end > next_start_q));
  assign sts_o.full       = count_q >= CW'(MaxRegions);
  assign sts_o.shift_done = (j_q == pos_q);
  assign sts_o.out_busy   = out_valid_q && rsp_stall_i;

  // write needs the write flag, a read of a present page is never allowed
  assign allowed = req_q.fault_code[FC_WRITE_BIT] ? rd_q.perm[PERM_WRITE_BIT] :
                   (!req_q.fault_code[FC_PRESENT_BIT] &&
                    (rd_q.perm[PERM_READ_BIT] || rd_q.perm[PERM_EXEC_BIT]));

  always_comb begin
    rsp_d = '0;
    if (cmd_i.res_sel == RES_HIT) begin
      rsp_d.status        = allowed ? ST_OK : ST_DENIED;
      rsp_d.hit_start     = rd_q.start_addr;
      rsp_d.hit_end       = rd_q.end_addr;
      rsp_d.hit_perm      = rd_q.perm;
      rsp_d.page_writable = allowed && rd_q.perm[PERM_WRITE_BIT];
    end else begin
      rsp_d.status = cmd_i.res_status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
    if (cmd_i.take_prev) begin
      prev_end_q <= rd_q.end_addr;
    end
    if (cmd_i.take_next) begin
      next_start_q <= rd_q.start_addr;
    end
    if (cmd_i.res_load) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q         <= '0;
      pos_q       <= '0;
      has_prev_q  <= 1'b0;
      has_next_q  <= 1'b0;
      count_q     <= '0;
      lh_idx_q    <= '0;
      lh_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.scan_clr) begin
        j_q        <= '0;
        has_prev_q <= 1'b0;
        has_next_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        j_q <= j_q + CW'(1);
      end else if (cmd_i.shift_init) begin
        j_q <= count_q;
      end else if (cmd_i.shift_write) begin
        j_q <= j_m1;
      end
      if (cmd_i.take_prev) begin
        has_prev_q <= 1'b1;
      end
      if (cmd_i.take_next) begin
        has_next_q <= 1'b1;
      end
      if (cmd_i.pos_at_j) begin
        pos_q <= j_q;
      end
      if (cmd_i.clear_tab) begin
        count_q    <= '0;
        lh_idx_q   <= '0;
        lh_valid_q <= 1'b0;
      end else if (cmd_i.ins_write) begin
        count_q <= count_q + CW'(1);
        // keep naming the same region after it moved up a slot
        if (lh_valid_q && (CW'(lh_idx_q) >= pos_q)) begin
          lh_idx_q <= lh_idx_q + IW'(1);
        end
      end else if (cmd_i.hit_scan) begin
        lh_idx_q   <= j_q[IW-1:0];
        lh_valid_q <= 1'b1;
      end else if (cmd_i.hit_last) begin
        lh_valid_q <= 1'b1;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxRegions))
    else $error("region count above table depth");

  a_last_hit_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lh_valid_q |-> (CW'(lh_idx_q) < count_q))
    else $error("last hit index outside filled table");

  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> !(out_valid_q && rsp_stall_i))
    else $error("result loaded over a stalled result");

  a_insert_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_write |-> (count_q < CW'(MaxRegions)) && (pos_q <= count_q))
    else $error("insert into a full table or past its end");
`endif

endmodule

@@ design/region_table_fault_check_core.sv @@
// Region table fault check: sorted table of address regions with fault permission lookup.
//
// One request channel (req_valid_i / req_stall_o / req_i) carries insert, fault check and
// clear requests; one result channel (rsp_valid_o / rsp_stall_i / rsp_o) returns exactly
// one result per request, in order. A request is taken when valid is high and stall low.
// Requests are handled one at a time; req_stall_o is high from the request being taken
// until its result has been loaded into the output register.
// The table is a single-port memory of MaxRegions entries; every entry visit is a read,
// then an evaluate on the registered read data. The steps of each request:
//   clear, unused code, empty or inverted range: result loaded from the dispatch state
//   fault check hitting the last-hit entry: that entry is read and evaluated alone
//   fault check by scan: entries read from the first until one holds the address, or
//   all of them when nothing holds it; the scan follows a last-hit entry that missed
//   insert: entries read to find the slot, then entries above it moved up one by one,
//   then the new region written; overlap or full table answers after the slot search
// A new request is taken in the cycle after the result is loaded.
// Reset empties the table (entry count and last-hit register cleared) at once.
// While the receiver stalls, the result is held; the block finishes the next request
// up to its result and then waits for the output register to free.
module region_table_fault_check_core #(
  parameter int unsigned MaxRegions = rtfc_pkg::DefMaxRegions
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_stall_o,
  input  rtfc_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_stall_i,
  output rtfc_pkg::rsp_t rsp_o
);
  import rtfc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rtfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rtfc_datapath #(
    .MaxRegions (MaxRegions)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

endmodule

@@ dv/region_table_fault_check_checker.sv @@
// checker for the region table block: predicts each result and compares it with the block
module region_table_fault_check_checker #(
  parameter int MaxRegions = rtfc_pkg::DefMaxRegions
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_stall_i,
  input  rtfc_pkg::req_t req_i,
  input  logic           rsp_valid_i,
  input  logic           rsp_stall_i,
  input  rtfc_pkg::rsp_t rsp_i,
  output int             mismatches_o,
  output int             awaited_o,
  output int             results_o,
  output int             peak_fill_o,
  output logic [7:0]     status_seen_o
);
  import rtfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // own copy of the region table
  logic [31:0] region_lo_q [MaxRegions];
  logic [31:0] region_hi_q [MaxRegions];
  logic [2:0]  region_flags_q [MaxRegions];
  int          region_count;
  int          recent_idx;
  logic        recent_valid;

  rsp_t expected_rsp_q [$];

  function automatic logic covers(input int idx, input logic [31:0] addr);
    return region_lo_q[idx] <= addr && addr < region_hi_q[idx];
  endfunction

  // works out the result of one request and updates the table copy
  function automatic rsp_t table_response(input req_t r);
    rsp_t o;
    int   pos;
    int   i;
    int   idx;
    logic found;
    logic allowed;
    o = '0;
    o.status = ST_OK;
    case (r.func)
      FUNC_INSERT: begin
        pos = 0;
        if (r.region_start >= r.region_end) begin
          o.status = ST_BAD_RANGE;
        end else begin
          while (pos < region_count && region_lo_q[pos] <= r.region_start) pos++;
          if (pos > 0 && region_hi_q[pos-1] > r.region_start) begin
            o.status = ST_BAD_RANGE;
          end else if (pos < region_count && r.region_end > region_lo_q[pos]) begin
            o.status = ST_BAD_RANGE;
          end else if (region_count >= MaxRegions) begin
            o.status = ST_FULL;
          end else begin
            for (i = region_count; i > pos; i--) begin
              region_lo_q[i]    = region_lo_q[i-1];
              region_hi_q[i]    = region_hi_q[i-1];
              region_flags_q[i] = region_flags_q[i-1];
            end
            region_lo_q[pos]    = r.region_start;
            region_hi_q[pos]    = r.region_end;
            region_flags_q[pos] = r.region_perm;
            region_count++;
            // remembered entry keeps naming the same region after the shift
            if (recent_valid && recent_idx >= pos) recent_idx++;
          end
        end
      end
      FUNC_FAULT: begin
        found = 1'b0;
        idx   = 0;
        if (recent_valid && recent_idx < region_count && covers(recent_idx, r.fault_addr)) begin
          found = 1'b1;
          idx   = recent_idx;
        end else begin
          for (i = 0; i < region_count && !found; i++) begin
            if (covers(i, r.fault_addr)) begin
              found = 1'b1;
              idx   = i;
            end
          end
        end
        if (!found) begin
          o.status = ST_NO_REGION;
        end else begin
          recent_idx   = idx;
          recent_valid = 1'b1;
          o.hit_start  = region_lo_q[idx];
          o.hit_end    = region_hi_q[idx];
          o.hit_perm   = region_flags_q[idx];
          if (r.fault_code[FC_WRITE_BIT]) begin
            allowed = o.hit_perm[PERM_WRITE_BIT];
          end else if (r.fault_code[FC_PRESENT_BIT]) begin
            // read of a present page is a protection fault
            allowed = 1'b0;
          end else begin
            allowed = o.hit_perm[PERM_READ_BIT] | o.hit_perm[PERM_EXEC_BIT];
          end
          if (allowed) begin
            o.page_writable = o.hit_perm[PERM_WRITE_BIT];
          end else begin
            o.status = ST_DENIED;
          end
        end
      end
      FUNC_CLEAR: begin
        region_count = 0;
        recent_valid = 1'b0;
        recent_idx   = 0;
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rsp_t want;
    if (!rst_ni) begin
      region_count  = 0;
      recent_idx    = 0;
      recent_valid  = 1'b0;
      mismatches_o  = 0;
      awaited_o     = 0;
      results_o     = 0;
      peak_fill_o   = 0;
      status_seen_o = '0;
      expected_rsp_q.delete();
    end else begin
      if (rsp_valid_i && !rsp_stall_i) begin
        results_o++;
        status_seen_o[rsp_i.status] = 1'b1;
        if (expected_rsp_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t chk: result with no request outstanding: %s",
                     $realtime,
                     $sformatf("st=%0d start=%h end=%h perm=%0d wr=%0b",
                               rsp_i.status, rsp_i.hit_start, rsp_i.hit_end,
                               rsp_i.hit_perm, rsp_i.page_writable));
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_i.status !== want.status || rsp_i.hit_start !== want.hit_start ||
              rsp_i.hit_end !== want.hit_end || rsp_i.hit_perm !== want.hit_perm ||
              rsp_i.page_writable !== want.page_writable) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("%0t chk: mismatch expected %s, got %s", $realtime,
                       $sformatf("st=%0d start=%h end=%h perm=%0d wr=%0b",
                                 want.status, want.hit_start, want.hit_end,
                                 want.hit_perm, want.page_writable),
                       $sformatf("st=%0d start=%h end=%h perm=%0d wr=%0b",
                                 rsp_i.status, rsp_i.hit_start, rsp_i.hit_end,
                                 rsp_i.hit_perm, rsp_i.page_writable));
          end
        end
      end
      if (req_valid_i && !req_stall_i) begin
        expected_rsp_q.push_back(table_response(req_i));
        if (region_count > peak_fill_o) peak_fill_o = region_count;
      end
      awaited_o = expected_rsp_q.size();
    end
  end

endmodule

@@ dv/region_table_fault_check_core_tb.sv @@
// testbench top for the region table block: stimulus, handshake pressure and verdict
module region_table_fault_check_core_tb;
  import rtfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FuncUnused = 2'd3;

  localparam logic [1:0] FcRead         = 2'd0;
  localparam logic [1:0] FcPresentRead  = 2'd1;
  localparam logic [1:0] FcWrite        = 2'd2;
  localparam logic [1:0] FcPresentWrite = 2'd3;

  localparam logic [2:0] PermNone = 3'd0;
  localparam logic [2:0] PermR    = 3'd1;
  localparam logic [2:0] PermW    = 3'd2;
  localparam logic [2:0] PermX    = 3'd4;

  localparam int          ArenaSlots = 24;
  localparam int          SlotSize   = 256;
  localparam logic [31:0] ArenaMask  = 32'hFFFF_F000;
  localparam int          LongHold   = 300;
  localparam int          TailCycles = 100;
  localparam int          QuietLimit = 4000;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic req_valid_i = 1'b0;
  req_t req_i       = '0;
  logic rsp_stall_i = 1'b0;
  logic req_stall_o;
  logic rsp_valid_o;
  rsp_t rsp_o;

  int         mismatches;
  int         awaited;
  int         results;
  int         peak_fill;
  logic [7:0] status_seen;

  logic tx_idle_en    = 1'b1;
  logic rx_idle_en    = 1'b1;
  logic hold_rsp_req  = 1'b0;
  logic hold_rsp_done = 1'b0;
  int   func_count [4];

  // address window that well-formed requests aim at
  logic [31:0] arena_base;
  logic [31:0] last_start;
  logic [31:0] last_end;

  region_table_fault_check_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o      (rsp_o)
  );

  region_table_fault_check_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_stall_i  (req_stall_o),
    .req_i        (req_i),
    .rsp_valid_i  (rsp_valid_o),
    .rsp_stall_i  (rsp_stall_i),
    .rsp_i        (rsp_o),
    .mismatches_o (mismatches),
    .awaited_o    (awaited),
    .results_o    (results),
    .peak_fill_o  (peak_fill),
    .status_seen_o(status_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic req_t plain_req(input logic [1:0] func);
    req_t r;
    r.func         = func;
    r.region_start = $urandom();
    r.region_end   = $urandom();
    r.region_perm  = 3'($urandom());
    r.fault_addr   = $urandom();
    r.fault_code   = 2'($urandom());
    return r;
  endfunction

  function automatic req_t insert_req(input logic [31:0] s, input logic [31:0] e,
                                      input logic [2:0] p);
    req_t r;
    r              = plain_req(FUNC_INSERT);
    r.region_start = s;
    r.region_end   = e;
    r.region_perm  = p;
    return r;
  endfunction

  function automatic req_t fault_req(input logic [31:0] a, input logic [1:0] c);
    req_t r;
    r            = plain_req(FUNC_FAULT);
    r.fault_addr = a;
    r.fault_code = c;
    return r;
  endfunction

  // mostly well-formed requests into the arena, with some noise
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    int unsigned slot;
    int unsigned lo;
    pick = $urandom_range(0, 99);
    r    = plain_req(FUNC_FAULT);
    if (pick < 6) begin
      r.func = 2'($urandom_range(0, 3));
    end else if (pick < 7) begin
      r.func = FUNC_CLEAR;
      case ($urandom_range(0, 5))
        0:       arena_base = '0;
        1:       arena_base = 32'hFFFF_E800;
        default: arena_base = $urandom() & ArenaMask;
      endcase
    end else if (pick < 8) begin
      r.func = FuncUnused;
    end else if (pick < 52) begin
      r.func         = FUNC_INSERT;
      slot           = $urandom_range(0, ArenaSlots - 1);
      lo             = $urandom_range(0, SlotSize - 1);
      r.region_start = arena_base + slot * SlotSize + lo;
      case ($urandom_range(0, 9))
        0:       r.region_end = r.region_start - $urandom_range(0, 2);
        1:       r.region_end = r.region_start + $urandom_range(1, 3 * SlotSize);
        default: r.region_end = arena_base + slot * SlotSize + $urandom_range(lo + 1, SlotSize);
      endcase
      last_start = r.region_start;
      last_end   = r.region_end;
    end else begin
      case ($urandom_range(0, 19))
        0, 1:    r.fault_addr = $urandom();
        2:       r.fault_addr = last_start;
        3:       r.fault_addr = last_end - 1;
        4:       r.fault_addr = last_end;
        default: r.fault_addr = arena_base + $urandom_range(0, ArenaSlots * SlotSize - 1);
      endcase
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (req_stall_o);
    func_count[r.func]++;
    @(negedge clk_i);
  endtask

  // result side: random stall bursts, plus one long hold-off on demand
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_rsp_req) begin
        rsp_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
        rsp_stall_i   <= 1'b0;
        hold_rsp_req  = 1'b0;
        hold_rsp_done = 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        rsp_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        rsp_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((req_valid_i && !req_stall_o) || (rsp_valid_o && !rsp_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t tb: no request or result moved for %0d cycles", $realtime, QuietLimit);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int k;
    int failures;
    foreach (func_count[i]) func_count[i] = 0;
    arena_base = $urandom() & ArenaMask;
    last_start = arena_base;
    last_end   = arena_base + SlotSize;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed corner cases
    send_request(plain_req(FUNC_CLEAR));
    send_request(fault_req(32'h0, FcRead));
    send_request(plain_req(FuncUnused));
    send_request(insert_req(32'h0, 32'h0, PermR | PermW | PermX));
    send_request(insert_req(32'hFFFF_FFFF, 32'h0, PermR | PermW | PermX));
    send_request(insert_req(32'h1000, 32'h2000, PermR | PermW));
    send_request(insert_req(32'hFFFF_F000, 32'hFFFF_FFFF, PermR | PermW | PermX));
    send_request(insert_req(32'h0, 32'h1, PermX));
    // same start as an existing region
    send_request(insert_req(32'h1000, 32'h1800, PermR));
    send_request(insert_req(32'h1800, 32'h2800, PermR));
    send_request(insert_req(32'h0800, 32'h1001, PermR));
    send_request(insert_req(32'h2000, 32'h3000, PermNone));
    send_request(fault_req(32'h1000, FcRead));
    send_request(fault_req(32'h1FFF, FcPresentRead));
    send_request(fault_req(32'h1FFF, FcWrite));
    send_request(fault_req(32'h1800, FcPresentWrite));
    // lands below the remembered entry, so its index moves up
    send_request(insert_req(32'h0800, 32'h1000, PermR));
    send_request(fault_req(32'h1004, FcRead));
    send_request(fault_req(32'h2000, FcRead));
    send_request(fault_req(32'h3000, FcRead));
    send_request(fault_req(32'hFFFF_FFFE, FcWrite));
    send_request(fault_req(32'hFFFF_FFFF, FcWrite));
    send_request(fault_req(32'h0, FcRead));
    send_request(plain_req(FUNC_CLEAR));
    send_request(fault_req(32'h1000, FcRead));

    repeat (600) send_request(random_request());

    // hold results back while requests keep coming, so the block backs up
    hold_rsp_req = 1'b1;
    tx_idle_en   = 1'b0;
    repeat (30) send_request(random_request());
    wait (hold_rsp_done);
    tx_idle_en = 1'b1;

    // let everything drain before going on
    req_valid_i <= 1'b0;
    wait (awaited == 0);
    @(negedge clk_i);

    // fill the table from the top down and past full; each insert that fits shifts every entry
    arena_base = $urandom() & ArenaMask;
    send_request(plain_req(FUNC_CLEAR));
    for (k = 19; k >= 0; k--) begin
      send_request(insert_req(arena_base + k * SlotSize, arena_base + k * SlotSize + SlotSize - 16,
                              3'($urandom())));
      if (k % 2 == 0)
        send_request(fault_req(arena_base + (k + 1) * SlotSize + 5, 2'($urandom())));
    end

    repeat (420) send_request(random_request());

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (150) send_request(random_request());

    req_valid_i <= 1'b0;
    wait (awaited == 0);
    repeat (TailCycles) @(posedge clk_i);

    failures = mismatches + awaited;
    $display("tb: sent %0d inserts, %0d fault checks, %0d clears, %0d unused codes",
             func_count[FUNC_INSERT], func_count[FUNC_FAULT], func_count[FUNC_CLEAR],
             func_count[FuncUnused]);
    $display("tb: %0d results checked, status codes seen %b, table held up to %0d regions",
             results, status_seen[4:0], peak_fill);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/rtfc_pkg.sv
design/rtfc_ctrl.sv
design/rtfc_datapath.sv
design/region_table_fault_check_core.sv
dv/region_table_fault_check_checker.sv
dv/region_table_fault_check_core_tb.sv
